### hw/rtl/kau_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kau_pkg
// Shared types and constants for the k-means assign/update block.
// ----------------------------------------------------------------------------
package kau_pkg;

    localparam int ACTION_W         = 2;
    localparam int SLOT_W           = 6;
    localparam int SAMPLE_W         = 16;
    localparam int CLUSTER_W        = 6;
    localparam int CFG_W            = 7;
    localparam logic [CFG_W-1:0] CFG_RESET = 7'd8;
    localparam int MAX_CLUSTERS_DEF = 64;
    localparam int MAX_POINTS_DEF   = 1048576;

    typedef enum logic [ACTION_W-1:0] {
        ACT_LOAD   = 2'd0,
        ACT_ASSIGN = 2'd1,
        ACT_UPDATE = 2'd2,
        ACT_NOP    = 2'd3
    } kau_action_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIST,
        ST_SCAN,
        ST_APUT,
        ST_UHEAD,
        ST_UDIV,
        ST_UPUT
    } kau_state_t;

    // Broadcast commands from the sequencer to every cell.
    typedef struct packed {
        logic load;
        logic measure;
        logic acc;
        logic shift;
    } kau_ctl_t;

endpackage

### hw/rtl/kau_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kau_cell
// One centroid cell: holds centroid, sum and count, compares its distance
// against the best one handed in from the left, rotates state on update.
// ----------------------------------------------------------------------------
module kau_cell #(
    parameter int INDEX      = 0,
    parameter int IW         = 6,
    parameter int KW         = 7,
    parameter int SW         = 37,
    parameter int CW         = 21,
    parameter int DW         = 33,
    parameter int MAX_POINTS = 1048576
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  kau_pkg::kau_ctl_t                   ctl_i,
    input  logic [KW-1:0]                       k_i,
    input  logic [kau_pkg::SLOT_W-1:0]          slot_i,
    input  logic signed [kau_pkg::SAMPLE_W-1:0] sample_i,
    input  logic [IW-1:0]                       win_i,
    input  logic                                scan_valid_i,
    input  logic [DW-1:0]                       scan_dist_i,
    input  logic [IW-1:0]                       scan_idx_i,
    output logic                                scan_valid_o,
    output logic [DW-1:0]                       scan_dist_o,
    output logic [IW-1:0]                       scan_idx_o,
    input  logic signed [kau_pkg::SAMPLE_W-1:0] shift_cent_i,
    input  logic signed [SW-1:0]                shift_sum_i,
    input  logic [CW-1:0]                       shift_cnt_i,
    output logic signed [kau_pkg::SAMPLE_W-1:0] cent_o,
    output logic signed [SW-1:0]                sum_o,
    output logic [CW-1:0]                       cnt_o
);
    import kau_pkg::*;

    logic signed [SAMPLE_W-1:0]   cent_reg;
    logic signed [SW-1:0]         sum_reg;
    logic [CW-1:0]                cnt_reg;
    logic [DW-1:0]                dist_reg;
    logic                         sv_reg;
    logic [DW-1:0]                sd_reg;
    logic [IW-1:0]                si_reg;
    logic signed [SAMPLE_W:0]     diff;
    logic signed [2*SAMPLE_W+1:0] prod;
    logic                         active;
    logic                         take;
    logic                         load_hit;

    assign diff     = {cent_reg[SAMPLE_W-1], cent_reg} - {sample_i[SAMPLE_W-1], sample_i};
    assign prod     = diff * diff;
    assign active   = KW'(INDEX) < k_i;
    assign take     = active && ((INDEX == 0) || (dist_reg < scan_dist_i));
    assign load_hit = (IW+SLOT_W)'(slot_i) == (IW+SLOT_W)'(INDEX);

    always_ff @(posedge aclk) begin
        if (ctl_i.measure) begin
            dist_reg <= prod[DW-1:0];
        end
        sd_reg <= take ? dist_reg : scan_dist_i;
        si_reg <= take ? IW'(INDEX) : scan_idx_i;
        if (ctl_i.shift) begin
            cent_reg <= shift_cent_i;
        end else if (ctl_i.load && load_hit) begin
            cent_reg <= sample_i;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sv_reg  <= 1'b0;
            sum_reg <= '0;
            cnt_reg <= '0;
        end else begin
            sv_reg <= scan_valid_i;
            if (ctl_i.shift) begin
                sum_reg <= shift_sum_i;
                cnt_reg <= shift_cnt_i;
            end else if (ctl_i.acc && (win_i == IW'(INDEX))
                         && (cnt_reg < CW'(MAX_POINTS))) begin
                sum_reg <= sum_reg + SW'(sample_i);
                cnt_reg <= cnt_reg + CW'(1);
            end
        end
    end

    assign scan_valid_o = sv_reg;
    assign scan_dist_o  = sd_reg;
    assign scan_idx_o   = si_reg;
    assign cent_o       = cent_reg;
    assign sum_o        = sum_reg;
    assign cnt_o        = cnt_reg;

endmodule

### hw/rtl/kau_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kau_div
// Bit-serial divider for the rounded mean (2|sum| + n) / 2n, signed result.
// ----------------------------------------------------------------------------
module kau_div #(
    parameter int SW = 37,
    parameter int CW = 21
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                start_i,
    input  logic signed [SW-1:0]                sum_i,
    input  logic [CW-1:0]                       cnt_i,
    output logic                                done_o,
    output logic signed [kau_pkg::SAMPLE_W-1:0] mean_o
);
    import kau_pkg::*;

    localparam int NW  = SW + 1;
    localparam int CNW = $clog2(NW + 1);

    logic [NW-1:0]  num_reg;
    logic [CW:0]    rem_reg;
    logic [CW:0]    den_reg;
    logic           neg_reg;
    logic [CNW-1:0] cnt_reg;
    logic           done_reg;
    logic [SW-1:0]  mag;
    logic [CW+1:0]  trial;
    logic           ge;
    logic [CW+1:0]  diffv;
    logic [SAMPLE_W-1:0] q;

    assign mag   = sum_i[SW-1] ? SW'(-sum_i) : SW'(sum_i);
    assign trial = {rem_reg, num_reg[NW-1]};
    assign ge    = trial >= {1'b0, den_reg};
    assign diffv = trial - {1'b0, den_reg};
    assign q     = num_reg[SAMPLE_W-1:0];

    always_ff @(posedge aclk) begin
        if (start_i) begin
            num_reg <= {mag, 1'b0} + NW'(cnt_i);
            rem_reg <= '0;
            den_reg <= {cnt_i, 1'b0};
            neg_reg <= sum_i[SW-1];
        end else if (cnt_reg != '0) begin
            num_reg <= {num_reg[NW-2:0], ge};
            rem_reg <= ge ? diffv[CW:0] : trial[CW:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= (cnt_reg == CNW'(1));
            if (start_i) begin
                cnt_reg <= CNW'(NW);
            end else if (cnt_reg != '0) begin
                cnt_reg <= cnt_reg - CNW'(1);
            end
        end
    end

    assign done_o = done_reg;
    assign mean_o = neg_reg ? -$signed(q) : $signed(q);

endmodule

### hw/rtl/kmeans_assign_update.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kmeans_assign_update
// One Lloyd iteration of 1-D k-means on Q8.8 samples, built as a cell row.
// ----------------------------------------------------------------------------
// A row of MAX_CLUSTERS cells holds the centroids, sums and counts. Words are
// taken one at a time. A load word gives no result. An assign word first has
// every cell square its distance, then the running best (distance, index)
// is handed cell to cell, one cell per cycle, lowest index winning ties; the
// winner then accumulates the point. An update word rotates the row once
// through the head cell, one cell per step: each active cluster with points
// goes through the shared bit-serial divider (SW = 16 + count width), and
// each new centroid waits in ST_UPUT until the output is free. The rotation
// writes zero sums and counts back into the tail, which clears them. The
// result register lets the next word in while a result waits to be taken.
// ----------------------------------------------------------------------------
module kmeans_assign_update #(
    parameter int MAX_CLUSTERS = kau_pkg::MAX_CLUSTERS_DEF,
    parameter int MAX_POINTS   = kau_pkg::MAX_POINTS_DEF
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_wr_en,
    input  logic [kau_pkg::CFG_W-1:0]           cfg_wr_data,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic [kau_pkg::ACTION_W-1:0]        s_action,
    input  logic [kau_pkg::SLOT_W-1:0]          s_slot,
    input  logic signed [kau_pkg::SAMPLE_W-1:0] s_sample,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic                                m_kind,
    output logic [kau_pkg::CLUSTER_W-1:0]       m_cluster,
    output logic signed [kau_pkg::SAMPLE_W-1:0] m_mean_value,
    output logic                                m_final_flag
);
    import kau_pkg::*;

    localparam int IW = $clog2(MAX_CLUSTERS);
    localparam int KW = $clog2(MAX_CLUSTERS + 1);
    localparam int CW = $clog2(MAX_POINTS + 1);
    localparam int SW = SAMPLE_W + CW;
    localparam int DW = 2 * SAMPLE_W + 1;
    localparam int XW = KW + CFG_W;

    // Configuration and effective k.
    logic [CFG_W-1:0] k_cfg_reg;
    logic [KW-1:0]    k_eff;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            k_cfg_reg <= CFG_RESET;
        end else if (cfg_wr_en) begin
            k_cfg_reg <= cfg_wr_data;
        end
    end

    always_comb begin
        if (k_cfg_reg == '0) begin
            k_eff = KW'(1);
        end else if (XW'(k_cfg_reg) > XW'(MAX_CLUSTERS)) begin
            k_eff = KW'(MAX_CLUSTERS);
        end else begin
            k_eff = KW'(k_cfg_reg);
        end
    end

    // Sequencer state.
    kau_state_t              state_reg, state_next;
    logic signed [SAMPLE_W-1:0] sample_reg;
    logic                    start_reg;
    logic [IW-1:0]           win_reg, win_next;
    logic [IW-1:0]           uidx_reg, uidx_next;
    logic signed [SAMPLE_W-1:0] hold_reg, hold_next;
    kau_ctl_t                ctl;
    logic                    div_start;
    logic                    div_done;
    logic signed [SAMPLE_W-1:0] div_mean;
    logic                    accept;
    logic                    out_free;
    logic                    put_assign;
    logic                    put_update;

    // Cell row wiring: index i feeds i+1 on the scan, i+1 feeds i on rotate.
    logic                    sc_v [MAX_CLUSTERS+1];
    logic [DW-1:0]           sc_d [MAX_CLUSTERS+1];
    logic [IW-1:0]           sc_i [MAX_CLUSTERS+1];
    logic signed [SAMPLE_W-1:0] rc [MAX_CLUSTERS+1];
    logic signed [SW-1:0]    rs [MAX_CLUSTERS+1];
    logic [CW-1:0]           rn [MAX_CLUSTERS+1];

    assign accept   = s_valid && s_ready;
    assign out_free = !m_valid || m_ready;
    assign s_ready  = (state_reg == ST_IDLE);

    assign sc_v[0] = start_reg;
    assign sc_d[0] = '0;
    assign sc_i[0] = '0;

    // Tail of the rotation: the head's new centroid (its old one when inactive), with sum and count cleared.
    assign rc[MAX_CLUSTERS] = (state_reg == ST_UPUT) ? hold_reg : rc[0];
    assign rs[MAX_CLUSTERS] = '0;
    assign rn[MAX_CLUSTERS] = '0;

    for (genvar g = 0; g < MAX_CLUSTERS; g++) begin : g_cell
        kau_cell #(
            .INDEX      (g),
            .IW         (IW),
            .KW         (KW),
            .SW         (SW),
            .CW         (CW),
            .DW         (DW),
            .MAX_POINTS (MAX_POINTS)
        ) u_cell (
            .aclk         (aclk),
            .aresetn      (aresetn),
            .ctl_i        (ctl),
            .k_i          (k_eff),
            .slot_i       (s_slot),
            .sample_i     (ctl.load ? s_sample : sample_reg),
            .win_i        (win_next),
            .scan_valid_i (sc_v[g]),
            .scan_dist_i  (sc_d[g]),
            .scan_idx_i   (sc_i[g]),
            .scan_valid_o (sc_v[g+1]),
            .scan_dist_o  (sc_d[g+1]),
            .scan_idx_o   (sc_i[g+1]),
            .shift_cent_i (rc[g+1]),
            .shift_sum_i  (rs[g+1]),
            .shift_cnt_i  (rn[g+1]),
            .cent_o       (rc[g]),
            .sum_o        (rs[g]),
            .cnt_o        (rn[g])
        );
    end

    kau_div #(
        .SW (SW),
        .CW (CW)
    ) u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start_i (div_start),
        .sum_i   (rs[0]),
        .cnt_i   (rn[0]),
        .done_o  (div_done),
        .mean_o  (div_mean)
    );

    // Next state and row commands.
    always_comb begin
        state_next = state_reg;
        win_next   = win_reg;
        uidx_next  = uidx_reg;
        hold_next  = hold_reg;
        ctl        = '0;
        div_start  = 1'b0;
        put_assign = 1'b0;
        put_update = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    unique case (kau_action_t'(s_action))
                        ACT_LOAD:   ctl.load = 1'b1;
                        ACT_ASSIGN: state_next = ST_DIST;
                        ACT_UPDATE: begin
                            uidx_next  = '0;
                            state_next = ST_UHEAD;
                        end
                        ACT_NOP:    state_next = ST_IDLE;
                        default:    state_next = ST_IDLE;
                    endcase
                end
            end
            ST_DIST: begin
                ctl.measure = 1'b1;
                state_next  = ST_SCAN;
            end
            ST_SCAN: begin
                // Accumulate into the winner as the best word leaves the row.
                if (sc_v[MAX_CLUSTERS]) begin
                    win_next   = sc_i[MAX_CLUSTERS];
                    ctl.acc    = 1'b1;
                    state_next = ST_APUT;
                end
            end
            ST_APUT: begin
                if (out_free) begin
                    put_assign = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            ST_UHEAD: begin
                if (KW'(uidx_reg) >= k_eff) begin
                    // Inactive cluster: rotate and clear only.
                    ctl.shift = 1'b1;
                    uidx_next = uidx_reg + IW'(1);
                    if (uidx_reg == IW'(MAX_CLUSTERS - 1)) begin
                        state_next = ST_IDLE;
                    end
                end else if (rn[0] == '0) begin
                    hold_next  = rc[0];
                    state_next = ST_UPUT;
                end else begin
                    div_start  = 1'b1;
                    state_next = ST_UDIV;
                end
            end
            ST_UDIV: begin
                if (div_done) begin
                    hold_next  = div_mean;
                    state_next = ST_UPUT;
                end
            end
            ST_UPUT: begin
                if (out_free) begin
                    put_update = 1'b1;
                    ctl.shift  = 1'b1;
                    uidx_next  = uidx_reg + IW'(1);
                    if (uidx_reg == IW'(MAX_CLUSTERS - 1)) begin
                        state_next = ST_IDLE;
                    end else begin
                        state_next = ST_UHEAD;
                    end
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            start_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            start_reg <= (state_reg == ST_DIST);
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            sample_reg <= s_sample;
        end
        win_reg  <= win_next;
        uidx_reg <= uidx_next;
        hold_reg <= hold_next;
    end

    // Result register: hold until taken.
    logic                       m_valid_reg;
    logic                       m_kind_reg;
    logic [CLUSTER_W-1:0]       m_cluster_reg;
    logic signed [SAMPLE_W-1:0] m_mean_reg;
    logic                       m_final_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (put_assign || put_update) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (put_assign) begin
            m_kind_reg    <= 1'b0;
            m_cluster_reg <= CLUSTER_W'(win_reg);
            m_mean_reg    <= '0;
            m_final_reg   <= 1'b1;
        end else if (put_update) begin
            m_kind_reg    <= 1'b1;
            m_cluster_reg <= CLUSTER_W'(uidx_reg);
            m_mean_reg    <= hold_reg;
            m_final_reg   <= (KW'(uidx_reg) + KW'(1)) == k_eff;
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_kind       = m_kind_reg;
    assign m_cluster    = m_cluster_reg;
    assign m_mean_value = m_mean_reg;
    assign m_final_flag = m_final_reg;

endmodule

### tb/kmeans_assign_update_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kmeans_assign_update_checker
// Predicts and checks every result word of the k-means assign/update block.
// ----------------------------------------------------------------------------
// Watches the register port and both channels at the rising edge. Each
// accepted input word runs through an own copy of the centroid table, the
// sums and the counts; the words that it should cause are queued and
// compared field by field with the result words in order.
// ----------------------------------------------------------------------------
module kmeans_assign_update_checker (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_wr_en,
    input  logic [kau_pkg::CFG_W-1:0]           cfg_wr_data,
    input  logic                                s_valid,
    input  logic                                s_ready,
    input  logic [kau_pkg::ACTION_W-1:0]        s_action,
    input  logic [kau_pkg::SLOT_W-1:0]          s_slot,
    input  logic signed [kau_pkg::SAMPLE_W-1:0] s_sample,
    input  logic                                m_valid,
    input  logic                                m_ready,
    input  logic                                m_kind,
    input  logic [kau_pkg::CLUSTER_W-1:0]       m_cluster,
    input  logic signed [kau_pkg::SAMPLE_W-1:0] m_mean_value,
    input  logic                                m_final_flag,
    output int                                  fail_count,
    output int                                  pending,
    output int                                  words_in,
    output int                                  words_out
);
    import kau_pkg::*;

    localparam int NCL  = MAX_CLUSTERS_DEF;
    localparam int NPTS = MAX_POINTS_DEF;

    typedef struct {
        logic                       kind;
        logic [CLUSTER_W-1:0]       cl;
        logic signed [SAMPLE_W-1:0] mean;
        logic                       fin;
    } kau_result_t;

    logic signed [SAMPLE_W-1:0] centroids [NCL];
    longint                     sums      [NCL];
    int                         counts    [NCL];
    logic [CFG_W-1:0]           k_reg;
    kau_result_t                expected_q [$];

    function automatic int active_k();
        if (k_reg == 0) return 1;
        if (k_reg > NCL) return NCL;
        return int'(k_reg);
    endfunction

    // Mean rounded to nearest, half away from zero.
    function automatic logic signed [SAMPLE_W-1:0] rounded_mean(longint sum, int cnt);
        longint mag;
        longint q;
        mag = (sum < 0) ? -sum : sum;
        q = (2 * mag + cnt) / (2 * longint'(cnt));
        return (sum < 0) ? SAMPLE_W'(-q) : SAMPLE_W'(q);
    endfunction

    function automatic void predict_word(kau_action_t act, logic [SLOT_W-1:0] sl,
                                         logic signed [SAMPLE_W-1:0] v);
        int          kk;
        int          best;
        longint      best_d;
        longint      d;
        kau_result_t r;
        kk = active_k();
        case (act)
            ACT_LOAD: begin
                centroids[sl] = v;
            end
            ACT_ASSIGN: begin
                best = 0;
                best_d = 0;
                for (int i = 0; i < kk; i++) begin
                    d = longint'(centroids[i]) - longint'(v);
                    d = d * d;
                    if (i == 0 || d < best_d) begin
                        best_d = d;
                        best = i;
                    end
                end
                if (counts[best] < NPTS) begin
                    sums[best] += longint'(v);
                    counts[best]++;
                end
                r.kind = 1'b0;
                r.cl = CLUSTER_W'(best);
                r.mean = '0;
                r.fin = 1'b1;
                expected_q = {expected_q, r};
            end
            ACT_UPDATE: begin
                for (int i = 0; i < kk; i++) begin
                    if (counts[i] != 0) centroids[i] = rounded_mean(sums[i], counts[i]);
                    r.kind = 1'b1;
                    r.cl = CLUSTER_W'(i);
                    r.mean = centroids[i];
                    r.fin = (i == kk - 1);
                    expected_q = {expected_q, r};
                end
                for (int i = 0; i < NCL; i++) begin
                    sums[i] = 0;
                    counts[i] = 0;
                end
            end
            default: ;
        endcase
    endfunction

    always @(posedge aclk) begin
        kau_result_t e;
        if (!aresetn) begin
            for (int i = 0; i < NCL; i++) begin
                centroids[i] = '0;
                sums[i] = 0;
                counts[i] = 0;
            end
            k_reg = CFG_RESET;
            expected_q.delete();
            fail_count = 0;
            words_in = 0;
            words_out = 0;
        end else begin
            if (m_valid && m_ready) begin
                words_out++;
                if (expected_q.size() == 0) begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("%0t: unexpected result word kind=%0d cluster=%0d mean=%0d",
                                 $realtime, m_kind, m_cluster, m_mean_value);
                end else begin
                    e = expected_q.pop_front();
                    if (m_kind !== e.kind || m_cluster !== e.cl ||
                        m_mean_value !== e.mean || m_final_flag !== e.fin) begin
                        fail_count++;
                        if (fail_count <= 10)
                            $display({"%0t: mismatch exp k=%0d c=%0d m=%0d f=%0d",
                                      " got k=%0d c=%0d m=%0d f=%0d"},
                                     $realtime, e.kind, e.cl, e.mean, e.fin,
                                     m_kind, m_cluster, m_mean_value, m_final_flag);
                    end
                end
            end
            if (s_valid && s_ready) begin
                words_in++;
                predict_word(kau_action_t'(s_action), s_slot, s_sample);
            end
            if (cfg_wr_en) k_reg = cfg_wr_data;
        end
        pending = expected_q.size();
    end

endmodule

### tb/kmeans_assign_update_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kmeans_assign_update_tb
// Stimulus and verdict for the k-means assign/update block.
// ----------------------------------------------------------------------------
// Loads every centroid, runs directed ties, extremes and an empty cluster,
// then random phases under several k settings with random stalls on both
// sides. The checker beside the block predicts and compares each result.
// ----------------------------------------------------------------------------
module kmeans_assign_update_tb;
    import kau_pkg::*;

    localparam int CYCLE_LIMIT = 10000000;

    logic                       aclk = 1'b0;
    logic                       aresetn = 1'b0;
    logic                       cfg_wr_en = 1'b0;
    logic [CFG_W-1:0]           cfg_wr_data = '0;
    logic                       s_valid = 1'b0;
    logic                       s_ready;
    logic [ACTION_W-1:0]        s_action = ACT_NOP;
    logic [SLOT_W-1:0]          s_slot = '0;
    logic signed [SAMPLE_W-1:0] s_sample = '0;
    logic                       m_valid;
    logic                       m_ready = 1'b0;
    logic                       m_kind;
    logic [CLUSTER_W-1:0]       m_cluster;
    logic signed [SAMPLE_W-1:0] m_mean_value;
    logic                       m_final_flag;

    int fail_count, pending, words_in, words_out;
    int cycles = 0;
    bit quiet = 1'b0;      // no idling on either side in the last phase
    bit hold_req = 1'b0;   // ask the receiver for one long hold-off
    int k_tried = 0;

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    kmeans_assign_update uut (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
        .s_valid(s_valid), .s_ready(s_ready), .s_action(s_action),
        .s_slot(s_slot), .s_sample(s_sample),
        .m_valid(m_valid), .m_ready(m_ready), .m_kind(m_kind),
        .m_cluster(m_cluster), .m_mean_value(m_mean_value),
        .m_final_flag(m_final_flag)
    );

    kmeans_assign_update_checker chk (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
        .s_valid(s_valid), .s_ready(s_ready), .s_action(s_action),
        .s_slot(s_slot), .s_sample(s_sample),
        .m_valid(m_valid), .m_ready(m_ready), .m_kind(m_kind),
        .m_cluster(m_cluster), .m_mean_value(m_mean_value),
        .m_final_flag(m_final_flag),
        .fail_count(fail_count), .pending(pending),
        .words_in(words_in), .words_out(words_out)
    );

    // Watchdog: drop the run if it hangs anywhere.
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    // Receiver: random stall bursts, plus one long hold-off on request.
    initial begin
        @(posedge aresetn);
        forever begin
            @(negedge aclk);
            if (hold_req) begin
                hold_req = 1'b0;
                m_ready <= 1'b0;
                repeat (600) @(negedge aclk);
            end else if (!quiet && $urandom_range(0, 7) == 0) begin
                m_ready <= 1'b0;
                repeat ($urandom_range(1, 16)) @(negedge aclk);
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    // Offer one word; return at the falling edge after it was taken, valid
    // still high so a following word can go out back to back.
    task automatic send_word(input kau_action_t act, input logic [SLOT_W-1:0] sl,
                             input logic [SAMPLE_W-1:0] v);
        if (!quiet && $urandom_range(0, 4) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 16)) @(negedge aclk);
        end
        s_valid  <= 1'b1;
        s_action <= act;
        s_slot   <= sl;
        s_sample <= v;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        @(negedge aclk);
    endtask

    // Drop valid, then wait on the falling clock edge.
    task automatic stop_words();
        s_valid <= 1'b0;
        @(negedge aclk);
    endtask

    // Hold the sender until all results are in and the block has settled.
    task automatic drain();
        stop_words();
        while (pending != 0) @(negedge aclk);
        repeat (150) @(negedge aclk);
    endtask

    task automatic write_k(input logic [CFG_W-1:0] val);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= val;
        @(negedge aclk);
        cfg_wr_en   <= 1'b0;
        @(negedge aclk);
        k_tried++;
    endtask

    task automatic random_word();
        int r;
        r = $urandom_range(0, 99);
        if (r < 4)
            send_word(ACT_NOP, SLOT_W'($urandom), SAMPLE_W'($urandom));
        else if (r < 16)
            send_word(ACT_LOAD, SLOT_W'($urandom), SAMPLE_W'($urandom));
        else if (r < 23)
            send_word(ACT_UPDATE, SLOT_W'($urandom), SAMPLE_W'($urandom));
        else if (r < 60)
            send_word(ACT_ASSIGN, SLOT_W'($urandom), SAMPLE_W'($urandom));
        else
            send_word(ACT_ASSIGN, SLOT_W'($urandom),
                      SAMPLE_W'($urandom_range(0, 2047) - 1024));
    endtask

    initial begin
        logic [CFG_W-1:0] k_plan [6];
        k_plan = '{7'd1, 7'd64, 7'd0, 7'd127, 7'd5, 7'd8};
        repeat (11) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;
        @(negedge aclk);

        // Fill every slot so no k ever reads an unwritten centroid.
        for (int i = 8; i < 64; i++)
            send_word(ACT_LOAD, SLOT_W'(i), SAMPLE_W'($urandom));
        send_word(ACT_LOAD, 6'd0, 16'sh8000);
        send_word(ACT_LOAD, 6'd1, 16'sh7FFF);
        send_word(ACT_LOAD, 6'd2, 16'sd0);
        send_word(ACT_LOAD, 6'd3, 16'sd100);
        send_word(ACT_LOAD, 6'd4, 16'sd300);
        send_word(ACT_LOAD, 6'd5, 16'sd300);
        send_word(ACT_LOAD, 6'd6, -16'sd5);
        send_word(ACT_LOAD, 6'd7, -16'sd7);

        // Ties go to the lower index; extremes; rounding both signs.
        send_word(ACT_ASSIGN, 6'd63, 16'sd200);
        send_word(ACT_ASSIGN, 6'd0, 16'sd300);
        send_word(ACT_ASSIGN, 6'd0, -16'sd6);
        send_word(ACT_ASSIGN, 6'd0, 16'sh8000);
        send_word(ACT_ASSIGN, 6'd0, 16'sh7FFF);
        send_word(ACT_ASSIGN, 6'd0, 16'sd1);
        send_word(ACT_ASSIGN, 6'd0, 16'sd2);
        send_word(ACT_ASSIGN, 6'd0, -16'sd8);
        send_word(ACT_ASSIGN, 6'd0, -16'sd9);
        send_word(ACT_NOP, 6'h3F, 16'shFFFF);
        send_word(ACT_LOAD, 6'd40, 16'sd1234);
        send_word(ACT_UPDATE, 6'd0, 16'sd0);
        send_word(ACT_UPDATE, 6'd0, 16'sd0);
        drain();

        // Random phases, one k setting each; the last one without idling.
        for (int p = 0; p < 6; p++) begin
            write_k(k_plan[p]);
            if (p == 5) quiet = 1'b1;
            for (int n = 0; n < 38; n++) begin
                if (p == 1 && n == 10) hold_req = 1'b1;
                if (p == 2 && n == 20) drain();
                random_word();
            end
            send_word(ACT_UPDATE, '0, '0);
            drain();
        end

        $display("Covered %0d input words and %0d result words over %0d k settings.",
                 words_in, words_out, k_tried);
        if (fail_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
